// ===== src/dipm_pkg.sv =====
package dipm_pkg;

  // Request kinds carried in s_axis_tuser
  localparam logic [2:0] REQ_TICK        = 3'd0;
  localparam logic [2:0] REQ_TOUCH       = 3'd1;
  localparam logic [2:0] REQ_EVENT_WAKE  = 3'd2;
  localparam logic [2:0] REQ_SET_PROFILE = 3'd3;
  localparam logic [2:0] REQ_SET_BASE    = 3'd4;
  localparam logic [2:0] REQ_CONSUME     = 3'd5;

  // Power modes
  localparam logic [1:0] MODE_ACTIVE = 2'd0;
  localparam logic [1:0] MODE_DIM    = 2'd1;
  localparam logic [1:0] MODE_OFF    = 2'd2;

  // Profiles
  localparam logic [1:0] PROF_WAITING  = 2'd0;
  localparam logic [1:0] PROF_INTER    = 2'd1;
  localparam logic [1:0] PROF_TRANSFER = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_DIM_WAIT  = 3'd0;
  localparam logic [2:0] CFG_DIM_INTER = 3'd1;
  localparam logic [2:0] CFG_OFF_AFTER = 3'd2;
  localparam logic [2:0] CFG_DIM_LEVEL = 3'd3;
  localparam logic [2:0] CFG_RAMP_STEP = 3'd4;
  localparam logic [2:0] CFG_WAKE_HOLD = 3'd5;

  localparam int unsigned CFG_DATA_W = 27;
  localparam int unsigned BASE_RESET_PCT_DEF = 60;

  // Register reset values
  localparam logic [26:0] DIM_WAIT_RST  = 27'd30000;
  localparam logic [26:0] DIM_INTER_RST = 27'd60000;
  localparam logic [26:0] OFF_AFTER_RST = 27'd120000;
  localparam logic [6:0]  DIM_LEVEL_RST = 7'd25;
  localparam logic [6:0]  RAMP_STEP_RST = 7'd6;
  localparam logic [15:0] WAKE_HOLD_RST = 16'd1500;

  // Backlight limits
  localparam logic [7:0] PCT_MAX      = 8'd100;
  localparam logic [7:0] BASE_MIN_PCT = 8'd5;

  typedef struct packed {
    logic [26:0] dim_after_wait_ms;
    logic [26:0] dim_after_inter_ms;
    logic [26:0] off_after_ms;
    logic [6:0]  dim_level_pct;
    logic [6:0]  ramp_step_pct;
    logic [15:0] wake_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  level_pct;
    logic [1:0]  profile_sel;
    logic [31:0] now_ms;
    logic [2:0]  req_type;
  } req_t;

  typedef struct packed {
    logic       answer_flag;
    logic       wake_pending;
    logic       cpu_low_request;
    logic       panel_asleep;
    logic [1:0] power_mode;
    logic [6:0] backlight_pct;
  } res_t;

endpackage

// ===== src/dipm_cfg_regs.sv =====
module dipm_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [2:0]                          cfg_index_i,
  input  logic [dipm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output dipm_pkg::cfg_t                      cfg_o
);
  import dipm_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the register write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DIM_WAIT:  cfg_d.dim_after_wait_ms  = cfg_data_i[26:0];
        CFG_DIM_INTER: cfg_d.dim_after_inter_ms = cfg_data_i[26:0];
        CFG_OFF_AFTER: cfg_d.off_after_ms       = cfg_data_i[26:0];
        CFG_DIM_LEVEL: cfg_d.dim_level_pct      = cfg_data_i[6:0];
        CFG_RAMP_STEP: cfg_d.ramp_step_pct      = cfg_data_i[6:0];
        CFG_WAKE_HOLD: cfg_d.wake_hold_ms       = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dim_after_wait_ms  <= DIM_WAIT_RST;
      cfg_q.dim_after_inter_ms <= DIM_INTER_RST;
      cfg_q.off_after_ms       <= OFF_AFTER_RST;
      cfg_q.dim_level_pct      <= DIM_LEVEL_RST;
      cfg_q.ramp_step_pct      <= RAMP_STEP_RST;
      cfg_q.wake_hold_ms       <= WAKE_HOLD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/dipm_state_logic.sv =====
module dipm_state_logic #(
  parameter int unsigned BASE_RESET_PCT = dipm_pkg::BASE_RESET_PCT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  dipm_pkg::req_t  req_i,
  input  dipm_pkg::cfg_t  cfg_i,
  output dipm_pkg::res_t  res_o
);
  import dipm_pkg::*;

  localparam logic [6:0] BaseRst = 7'(BASE_RESET_PCT);

  logic [1:0]  mode_q, mode_d;
  logic [1:0]  profile_q, profile_d;
  logic [31:0] last_act_q, last_act_d;
  logic [6:0]  base_q, base_d;
  logic [6:0]  cur_q, cur_d;
  logic [6:0]  tgt_q, tgt_d;
  logic        wake_q, wake_d;
  logic [31:0] wake_ms_q, wake_ms_d;

  logic        answer;
  logic [6:0]  step;
  logic [6:0]  ramp_cur;
  logic [6:0]  diff;
  logic [31:0] idle;
  logic [31:0] wake_age;
  logic [26:0] tdim;
  logic [6:0]  dim_lvl;
  logic [7:0]  lvl_clamped;
  logic        go_wake;
  logic        was_off;
  logic [6:0]  wake_base;

  // Tick arithmetic: ramp, idle time, flag age; also dim threshold, dim level and base clamp
  always_comb begin
    step     = (cfg_i.ramp_step_pct == 7'd0) ? 7'd1 : cfg_i.ramp_step_pct;
    diff     = cur_q - tgt_q;
    if (cur_q < tgt_q) begin
      ramp_cur = tgt_q;
    end else if (cur_q > tgt_q) begin
      ramp_cur = (diff <= step) ? tgt_q : cur_q - step;
    end else begin
      ramp_cur = cur_q;
    end
    idle     = req_i.now_ms - last_act_q;
    wake_age = req_i.now_ms - wake_ms_q;
    tdim     = (profile_q == PROF_INTER) ? cfg_i.dim_after_inter_ms
                                         : cfg_i.dim_after_wait_ms;
    dim_lvl  = ({1'b0, cfg_i.dim_level_pct} > PCT_MAX) ? PCT_MAX[6:0]
                                                       : cfg_i.dim_level_pct;
    if (req_i.level_pct > PCT_MAX) begin
      lvl_clamped = PCT_MAX;
    end else if (req_i.level_pct < BASE_MIN_PCT) begin
      lvl_clamped = BASE_MIN_PCT;
    end else begin
      lvl_clamped = req_i.level_pct;
    end
  end

  // Next state for the request held in the input register
  always_comb begin
    mode_d     = mode_q;
    profile_d  = profile_q;
    last_act_d = last_act_q;
    base_d     = base_q;
    cur_d      = cur_q;
    tgt_d      = tgt_q;
    wake_d     = wake_q;
    wake_ms_d  = wake_ms_q;
    answer     = 1'b0;
    go_wake    = 1'b0;
    wake_base  = base_q;

    case (req_i.req_type)
      REQ_TICK: begin
        cur_d = ramp_cur;
        if (wake_q && (wake_age > {16'd0, cfg_i.wake_hold_ms})) begin
          wake_d = 1'b0;
        end
        if (mode_q == MODE_ACTIVE) begin
          if (idle >= {5'd0, tdim}) begin
            mode_d = MODE_DIM;
            tgt_d  = dim_lvl;
          end
        end else if (mode_q == MODE_DIM) begin
          if (profile_q != PROF_INTER && idle >= {5'd0, cfg_i.off_after_ms}) begin
            mode_d = MODE_OFF;
            tgt_d  = 7'd0;
            cur_d  = 7'd0;
          end
        end
      end
      REQ_TOUCH, REQ_EVENT_WAKE: go_wake = 1'b1;
      REQ_SET_PROFILE: begin
        if (req_i.profile_sel <= PROF_TRANSFER && req_i.profile_sel != profile_q) begin
          profile_d = req_i.profile_sel;
          go_wake   = 1'b1;
        end
      end
      REQ_SET_BASE: begin
        base_d    = lvl_clamped[6:0];
        wake_base = lvl_clamped[6:0];
        go_wake   = 1'b1;
        tgt_d     = lvl_clamped[6:0];
        cur_d     = lvl_clamped[6:0];
      end
      REQ_CONSUME: begin
        answer = wake_q;
        wake_d = 1'b0;
      end
      default: ;
    endcase

    // Wake path: record activity and restore the base level
    was_off = go_wake && (mode_q == MODE_OFF);
    if (go_wake) begin
      last_act_d = req_i.now_ms;
      if (mode_q != MODE_ACTIVE) begin
        mode_d = MODE_ACTIVE;
        tgt_d  = wake_base;
        cur_d  = wake_base;
      end
    end

    // Wake flag handling for touch and event wake
    if (req_i.req_type == REQ_TOUCH && was_off) begin
      wake_d    = 1'b1;
      wake_ms_d = req_i.now_ms;
    end
    if (req_i.req_type == REQ_EVENT_WAKE) begin
      answer = was_off;
      wake_d = 1'b0;
    end
  end

  // Result reflects the state after the request
  always_comb begin
    res_o.backlight_pct   = cur_d;
    res_o.power_mode      = mode_d;
    res_o.panel_asleep    = (mode_d == MODE_OFF);
    res_o.cpu_low_request = (mode_d == MODE_OFF);
    res_o.wake_pending    = wake_d;
    res_o.answer_flag     = answer;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_ACTIVE;
      profile_q  <= PROF_WAITING;
      last_act_q <= 32'd0;
      base_q     <= BaseRst;
      cur_q      <= BaseRst;
      tgt_q      <= BaseRst;
      wake_q     <= 1'b0;
      wake_ms_q  <= 32'd0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      profile_q  <= profile_d;
      last_act_q <= last_act_d;
      base_q     <= base_d;
      cur_q      <= cur_d;
      tgt_q      <= tgt_d;
      wake_q     <= wake_d;
      wake_ms_q  <= wake_ms_d;
    end
  end

endmodule

// ===== src/display_idle_power_manager_core.sv =====
// Backlight power manager with active, dim and off modes. Each request on
// the slave stream carries a millisecond timestamp and a request kind in
// s_axis_tuser; every request yields exactly one result on the master stream
// with the applied backlight percent, the mode after the request, the panel
// sleep and low CPU clock requests, the wake-swallow flag and the answer bit.
// Requests go through an input register and one pass of compare and subtract
// logic into an output register, so one request is taken every clock cycle
// while the result side is not stalled, with results shown from the output
// register; a stalled result holds both registers until m_axis_tready returns.
// Write the configuration registers only while no request is in flight.
module display_idle_power_manager_core #(
  parameter int unsigned BASE_RESET_PCT = dipm_pkg::BASE_RESET_PCT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] now_ms, [33:32] profile_sel, [41:34] level_pct, [47:42] zero
  input  logic [47:0]                      s_axis_tdata,
  // [2:0] req_type
  input  logic [2:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [6:0] backlight_pct, [8:7] power_mode, [9] panel_asleep,
  // [10] cpu_low_request, [11] wake_pending, [12] answer_flag, [15:13] zero
  output logic [15:0]                      m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [2:0]                       cfg_index_i,
  input  logic [dipm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import dipm_pkg::*;

  cfg_t cfg;
  req_t in_q;
  logic in_valid_q;
  res_t res;
  res_t out_q;
  logic out_valid_q;
  logic out_free;
  logic advance;

  dipm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Move the held request into the result register when there is room
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  dipm_state_logic #(
    .BASE_RESET_PCT (BASE_RESET_PCT)
  ) u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .req_i  (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register valid and result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.req_type    <= s_axis_tuser;
      in_q.now_ms      <= s_axis_tdata[31:0];
      in_q.profile_sel <= s_axis_tdata[33:32];
      in_q.level_pct   <= s_axis_tdata[41:34];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_q};

endmodule

// ===== tb/display_idle_power_manager_core_tb.sv =====
`timescale 1ns / 1ps

module display_idle_power_manager_core_tb;
  import dipm_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned PHASE_ITEMS  = 100;

  // Expected backlight results, predicted from accepted requests
  class power_scoreboard;
    logic [26:0] dim_wait;
    logic [26:0] dim_inter;
    logic [26:0] off_after;
    logic [6:0]  dim_level;
    logic [6:0]  ramp_step;
    logic [15:0] wake_hold;
    logic [1:0]  mode;
    logic [1:0]  profile;
    logic [31:0] last_act_ms;
    logic [6:0]  base_pct;
    logic [6:0]  cur_pct;
    logic [6:0]  target_pct;
    bit          armed;
    logic [31:0] armed_ms;
    res_t        result_q[$];
    int unsigned errors;

    function new();
      dim_wait    = DIM_WAIT_RST;
      dim_inter   = DIM_INTER_RST;
      off_after   = OFF_AFTER_RST;
      dim_level   = DIM_LEVEL_RST;
      ramp_step   = RAMP_STEP_RST;
      wake_hold   = WAKE_HOLD_RST;
      mode        = MODE_ACTIVE;
      profile     = PROF_WAITING;
      last_act_ms = '0;
      base_pct    = 7'(BASE_RESET_PCT_DEF);
      cur_pct     = 7'(BASE_RESET_PCT_DEF);
      target_pct  = 7'(BASE_RESET_PCT_DEF);
      armed       = 1'b0;
      armed_ms    = '0;
      errors      = 0;
    endfunction

    function int unsigned pending();
      return result_q.size();
    endfunction

    // Mirror one register write
    function void write_register(logic [2:0] idx, logic [26:0] data);
      case (idx)
        CFG_DIM_WAIT:  dim_wait  = data;
        CFG_DIM_INTER: dim_inter = data;
        CFG_OFF_AFTER: off_after = data;
        CFG_DIM_LEVEL: dim_level = data[6:0];
        CFG_RAMP_STEP: ramp_step = data[6:0];
        CFG_WAKE_HOLD: wake_hold = data[15:0];
        default: ;
      endcase
    endfunction

    // Record activity; leave dim or off with the base level restored
    function bit wake_up(logic [31:0] now);
      bit was_off;
      last_act_ms = now;
      if (mode == MODE_ACTIVE) return 1'b0;
      was_off    = (mode == MODE_OFF);
      mode       = MODE_ACTIVE;
      target_pct = base_pct;
      cur_pct    = base_pct;
      return was_off;
    endfunction

    // Ramp the level, expire the wake flag, then check idle thresholds
    function void tick(logic [31:0] now);
      logic [6:0]  step;
      logic [31:0] held;
      logic [31:0] idle;
      logic [26:0] dim_thr;
      step = (ramp_step == 7'd0) ? 7'd1 : ramp_step;
      if (cur_pct < target_pct) begin
        cur_pct = target_pct;
      end else if (cur_pct > target_pct) begin
        if (cur_pct - target_pct <= step) cur_pct = target_pct;
        else cur_pct = cur_pct - step;
      end
      held = now - armed_ms;
      if (armed && held > {16'd0, wake_hold}) armed = 1'b0;
      idle    = now - last_act_ms;
      dim_thr = (profile == PROF_INTER) ? dim_inter : dim_wait;
      if (mode == MODE_ACTIVE) begin
        if (idle >= {5'd0, dim_thr}) begin
          mode       = MODE_DIM;
          target_pct = (dim_level > PCT_MAX) ? PCT_MAX[6:0] : dim_level;
        end
      end else if (mode == MODE_DIM) begin
        if (profile != PROF_INTER && idle >= {5'd0, off_after}) begin
          target_pct = '0;
          cur_pct    = '0;
          mode       = MODE_OFF;
        end
      end
    endfunction

    // Advance the state by one accepted request and queue its result
    function void note_request(req_t r);
      logic [7:0] lvl;
      bit         answer;
      res_t       e;
      answer = 1'b0;
      case (r.req_type)
        REQ_TICK: tick(r.now_ms);
        REQ_TOUCH: begin
          if (wake_up(r.now_ms)) begin
            armed    = 1'b1;
            armed_ms = r.now_ms;
          end
        end
        REQ_EVENT_WAKE: begin
          answer = wake_up(r.now_ms);
          armed  = 1'b0;
        end
        REQ_SET_PROFILE: begin
          if (r.profile_sel <= PROF_TRANSFER && r.profile_sel != profile) begin
            profile = r.profile_sel;
            void'(wake_up(r.now_ms));
          end
        end
        REQ_SET_BASE: begin
          lvl = r.level_pct;
          if (lvl > PCT_MAX) lvl = PCT_MAX;
          if (lvl < BASE_MIN_PCT) lvl = BASE_MIN_PCT;
          base_pct = lvl[6:0];
          void'(wake_up(r.now_ms));
          target_pct = base_pct;
          cur_pct    = base_pct;
        end
        REQ_CONSUME: begin
          answer = armed;
          armed  = 1'b0;
        end
        default: ;
      endcase
      e.backlight_pct   = cur_pct;
      e.power_mode      = mode;
      e.panel_asleep    = (mode == MODE_OFF);
      e.cpu_low_request = (mode == MODE_OFF);
      e.wake_pending    = armed;
      e.answer_flag     = answer;
      result_q.push_back(e);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    // Match one accepted result against the oldest prediction
    function void check_result(res_t got);
      res_t e;
      if (result_q.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        errors++;
        return;
      end
      e = result_q.pop_front();
      compare_field("backlight_pct", e.backlight_pct, got.backlight_pct);
      compare_field("power_mode", e.power_mode, got.power_mode);
      compare_field("panel_asleep", e.panel_asleep, got.panel_asleep);
      compare_field("cpu_low_request", e.cpu_low_request, got.cpu_low_request);
      compare_field("wake_pending", e.wake_pending, got.wake_pending);
      compare_field("answer_flag", e.answer_flag, got.answer_flag);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  power_scoreboard board = new();
  bit              quiet;
  logic [31:0]     clock_ms;
  int unsigned     cycles = 0;

  display_idle_power_manager_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stall the result side at random
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 30);
    end
  end

  // Check results and bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("display_idle_power_manager_core_tb: FAIL");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(res_t'(m_axis_tdata[12:0]));
  end

  // Offer one request, with random gaps; entered and left at a falling edge
  task automatic send_event(logic [2:0] kind, logic [31:0] now, logic [1:0] psel,
                            logic [7:0] lvl);
    req_t r;
    r.req_type    = kind;
    r.now_ms      = now;
    r.profile_sel = psel;
    r.level_pct   = lvl;
    while (!quiet && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'd0, lvl, psel, now};
    s_axis_tuser  = kind;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(r);
    @(negedge clk_i);
  endtask

  // Random request; time mostly advances by up to adv_max
  task automatic random_event(int unsigned adv_max);
    int unsigned pick;
    logic [2:0]  kind;
    pick = $urandom_range(0, 99);
    if (pick < 45)      kind = REQ_TICK;
    else if (pick < 60) kind = REQ_TOUCH;
    else if (pick < 68) kind = REQ_EVENT_WAKE;
    else if (pick < 76) kind = REQ_SET_PROFILE;
    else if (pick < 86) kind = REQ_SET_BASE;
    else if (pick < 95) kind = REQ_CONSUME;
    else kind = 3'($urandom_range(6, 7));
    if ($urandom_range(0, 99) < 3) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, adv_max);
    send_event(kind, clock_ms, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  // Drop valid, wait until every result is back, then wait DRAIN_CYCLES more falling edges
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(logic [2:0] idx, logic [26:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Load a full register set while the block is idle
  task automatic apply_settings(logic [26:0] dw, logic [26:0] di, logic [26:0] off,
                                logic [26:0] lvl, logic [26:0] ramp, logic [26:0] hold);
    drain();
    write_register(CFG_DIM_WAIT, dw);
    write_register(CFG_DIM_INTER, di);
    write_register(CFG_OFF_AFTER, off);
    write_register(CFG_DIM_LEVEL, lvl);
    write_register(CFG_RAMP_STEP, ramp);
    write_register(CFG_WAKE_HOLD, hold);
  endtask

  task automatic run_phase(int unsigned adv_max);
    clock_ms = $urandom();
    repeat (PHASE_ITEMS) random_event(adv_max);
  endtask

  // Main stimulus
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_TICK;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_DIM_WAIT;
    cfg_data_i    = '0;
    quiet         = 1'b0;
    clock_ms      = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed pass with reset settings
    send_event(REQ_TICK, 32'd0, PROF_WAITING, 8'd0);
    send_event(REQ_CONSUME, 32'd10, PROF_WAITING, 8'd0);
    send_event(REQ_SET_PROFILE, 32'd20, 2'd3, 8'd0);
    send_event(REQ_SET_PROFILE, 32'd30, PROF_WAITING, 8'd0);
    send_event(REQ_SET_BASE, 32'd40, PROF_WAITING, 8'd255);
    send_event(REQ_SET_BASE, 32'd50, PROF_WAITING, 8'd0);
    send_event(REQ_SET_BASE, 32'd60, PROF_WAITING, 8'd60);
    send_event(3'd6, 32'd70, 2'd3, 8'd255);
    send_event(3'd7, 32'd80, PROF_WAITING, 8'd0);
    send_event(REQ_TICK, 32'd30060, PROF_WAITING, 8'd0);
    send_event(REQ_TICK, 32'd30070, PROF_WAITING, 8'd0);
    send_event(REQ_TICK, 32'd150060, PROF_WAITING, 8'd0);
    send_event(REQ_CONSUME, 32'd150080, PROF_WAITING, 8'd0);
    send_event(REQ_TOUCH, 32'd150100, PROF_WAITING, 8'd0);
    send_event(REQ_CONSUME, 32'd150200, PROF_WAITING, 8'd0);
    send_event(REQ_TICK, 32'd180200, PROF_WAITING, 8'd0);
    send_event(REQ_TICK, 32'd400000, PROF_WAITING, 8'd0);
    send_event(REQ_EVENT_WAKE, 32'd400010, PROF_WAITING, 8'd0);
    send_event(REQ_TOUCH, 32'd400020, PROF_WAITING, 8'd0);
    send_event(REQ_SET_PROFILE, 32'd400030, PROF_INTER, 8'd0);
    send_event(REQ_TICK, 32'd460030, PROF_WAITING, 8'd0);
    send_event(REQ_TICK, 32'hFFFF_FFF0, PROF_WAITING, 8'd0);
    send_event(REQ_SET_PROFILE, 32'hFFFF_FFF8, PROF_TRANSFER, 8'd0);
    send_event(REQ_TOUCH, 32'd5, PROF_WAITING, 8'd0);

    // All-zero thresholds, dim level and ramp step
    apply_settings('0, '0, '0, '0, '0, '0);
    run_phase(20);

    // Every register bit set: dim level saturates, thresholds are huge
    apply_settings('1, '1, '1, '1, '1, '1);
    run_phase(32'h1000_0000);

    // Largest legal values, no idling on either side
    quiet = 1'b1;
    apply_settings(27'd86400000, 27'd86400000, 27'd86400000, 27'd100, 27'd100, 27'd65535);
    run_phase(32'h0800_0000);
    quiet = 1'b0;

    // Short random settings so dim, off and wake expiry come often
    repeat (5) begin
      apply_settings(27'($urandom_range(1, 400)), 27'($urandom_range(1, 400)),
                     27'($urandom_range(1, 400)), 27'($urandom_range(0, 110)),
                     27'($urandom_range(0, 20)), 27'($urandom_range(0, 300)));
      run_phase(150);
    end

    drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("display_idle_power_manager_core_tb: PASS");
    end else begin
      $display("display_idle_power_manager_core_tb: FAIL");
    end
    $finish;
  end

endmodule
